// ----- rtl/core/lsm_pkg.sv -----
// shared types and constants for the shared/exclusive lock manager
package lsm_pkg;

  localparam int unsigned MaxResults = 32;
  localparam int unsigned ResCntW    = 6;

  localparam logic [1:0] CmdRequest = 2'd0;
  localparam logic [1:0] CmdRelease = 2'd1;
  localparam logic [1:0] CmdCancel  = 2'd2;
  localparam logic [1:0] CmdNop     = 2'd3;

  localparam logic ModeExcl   = 1'b0;
  localparam logic ModeShared = 1'b1;

  localparam logic [2:0] StGranted  = 3'd0;
  localparam logic [2:0] StNotAvail = 3'd1;
  localparam logic [2:0] StCanceled = 3'd2;
  localparam logic [2:0] StEjected  = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] requester_id;
    logic [7:0] lock_id;
    logic       mode;
    logic       no_wait;
    logic       steal;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] notify_id;
    logic [7:0] notify_lock;
    logic       notify_mode;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [7:0] who;
    logic [7:0] lk;
    logic       md;
  } slot_t;

  typedef struct packed {
    logic clash;
    logic lock_eq;
    logic owner_eq;
  } cmp_t;

endpackage

// ----- rtl/core/lsm_compare.sv -----
// compare unit: checks one stored entry against the target lock request
module lsm_compare (
  input  lsm_pkg::slot_t ent_i,
  input  lsm_pkg::slot_t tgt_i,
  output lsm_pkg::cmp_t  res_o
);

  logic lk_eq;

  assign lk_eq          = (ent_i.lk == tgt_i.lk);
  assign res_o.lock_eq  = lk_eq;
  assign res_o.owner_eq = lk_eq && (ent_i.who == tgt_i.who);
  assign res_o.clash    = lk_eq && ((tgt_i.md == lsm_pkg::ModeExcl) ||
                                    (ent_i.md == lsm_pkg::ModeExcl));

endmodule

// ----- rtl/core/named_shared_exclusive_lock_manager_unit.sv -----
// lock manager top: held table, ordered request queue, scan sequencer, result staging
// sequence: dispatch, then a scan of the tables; each queue position examined takes a pick
//   step, then a scan of the held table and of the earlier waiters
// throughput: one command at a time, in_ready_o is high only while idle; a result that finds
//   both the staging and the output register full holds the scan until the output drains
// reset: both tables empty, no result pending; in_ready_o is high out of reset
module named_shared_exclusive_lock_manager_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned HELD_DEPTH  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lsm_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lsm_pkg::rsp_t out_data_o
);

  localparam int unsigned QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned HW  = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HCW = $clog2(HELD_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_EJECT, S_RELEASE, S_CANCEL, S_PICK, S_GH, S_GQ, S_FIN
  } state_e;

  state_e              state_q, state_d;
  lsm_pkg::req_t       req_q;
  logic                av_q, av_d;
  logic [QCW-1:0]      qcnt_q, qcnt_d;
  logic [HCW-1:0]      hcnt_q, hcnt_d;
  logic [QCW-1:0]      pi_q, pi_d;
  logic [6:0]          j_q, j_d;
  logic [lsm_pkg::ResCntW-1:0] n_q, n_d;

  lsm_pkg::slot_t      queue_q [QUEUE_DEPTH];
  lsm_pkg::slot_t      held_q  [HELD_DEPTH];

  logic                pend_valid_q;
  lsm_pkg::rsp_t       pend_q;
  logic                out_valid_q;
  lsm_pkg::rsp_t       out_q;
  lsm_pkg::rsp_t       fin_rsp;

  // table update strobes
  logic                q_rm, q_back, q_front, h_rm, h_push;
  logic [QW-1:0]       q_rm_idx;
  logic [HW-1:0]       h_rm_idx;
  lsm_pkg::slot_t      h_push_val;

  // result request
  logic                emit_req, emit_live, stall, fin_load;
  lsm_pkg::rsp_t       emit_val;
  logic                out_free;

  lsm_pkg::slot_t      cmd_slot, q_pick, ent, tgt;
  lsm_pkg::cmp_t       cmp;
  logic                use_held;
  logic [QW-1:0]       jq;
  logic [HW-1:0]       jh;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // staged result tagged as the final one of its command
  assign fin_rsp = '{status: pend_q.status, notify_id: pend_q.notify_id,
                     notify_lock: pend_q.notify_lock, notify_mode: pend_q.notify_mode,
                     last: 1'b1};

  assign cmd_slot = '{who: req_q.requester_id, lk: req_q.lock_id, md: req_q.mode};
  assign q_pick   = queue_q[pi_q[QW-1:0]];
  assign jq       = j_q[QW-1:0];
  assign jh       = j_q[HW-1:0];
  assign use_held = (state_q == S_EJECT) || (state_q == S_RELEASE) || (state_q == S_GH);
  assign ent      = use_held ? held_q[jh] : queue_q[jq];
  assign tgt      = ((state_q == S_GH || state_q == S_GQ) && !av_q) ? q_pick : cmd_slot;

  lsm_compare u_cmp (
    .ent_i (ent),
    .tgt_i (tgt),
    .res_o (cmp)
  );

  always_comb begin
    logic [QCW-1:0] lim;
    logic           n_full;
    state_d    = state_q;
    av_d       = av_q;
    qcnt_d     = qcnt_q;
    hcnt_d     = hcnt_q;
    pi_d       = pi_q;
    j_d        = j_q;
    n_d        = n_q;
    q_rm       = 1'b0;
    q_back     = 1'b0;
    q_front    = 1'b0;
    h_rm       = 1'b0;
    h_push     = 1'b0;
    q_rm_idx   = jq;
    h_rm_idx   = jh;
    h_push_val = q_pick;
    emit_req   = 1'b0;
    emit_val   = '{status: lsm_pkg::StGranted, notify_id: req_q.requester_id,
                   notify_lock: req_q.lock_id, notify_mode: req_q.mode, last: 1'b0};
    fin_load   = 1'b0;
    n_full     = (n_q >= lsm_pkg::ResCntW'(lsm_pkg::MaxResults));
    lim        = av_q ? qcnt_q : pi_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISPATCH;
          n_d     = '0;
          j_d     = '0;
          pi_d    = '0;
          av_d    = 1'b0;
        end
      end
      S_DISPATCH: begin
        case (req_q.cmd)
          lsm_pkg::CmdRequest: begin
            if (req_q.steal) begin
              if (qcnt_q >= QCW'(QUEUE_DEPTH)) begin
                emit_req = 1'b1;
                emit_val.status = lsm_pkg::StFull;
                state_d = S_FIN;
              end else begin
                state_d = S_EJECT;
              end
            end else if (req_q.no_wait) begin
              av_d    = 1'b1;
              state_d = S_GH;
            end else if (qcnt_q >= QCW'(QUEUE_DEPTH)) begin
              emit_req = 1'b1;
              emit_val.status = lsm_pkg::StFull;
              state_d = S_FIN;
            end else begin
              q_back  = 1'b1;
              qcnt_d  = qcnt_q + 1'b1;
              state_d = S_PICK;
            end
          end
          lsm_pkg::CmdRelease: state_d = S_RELEASE;
          lsm_pkg::CmdCancel:  state_d = S_CANCEL;
          default:             state_d = S_FIN;
        endcase
      end
      S_EJECT: begin
        if (7'(j_q) >= 7'(hcnt_q)) begin
          q_front = 1'b1;
          qcnt_d  = qcnt_q + 1'b1;
          state_d = S_PICK;
        end else if (cmp.lock_eq) begin
          emit_req = 1'b1;
          emit_val = '{status: lsm_pkg::StEjected, notify_id: ent.who,
                       notify_lock: req_q.lock_id, notify_mode: ent.md, last: 1'b0};
          h_rm   = 1'b1;
          hcnt_d = hcnt_q - 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_RELEASE: begin
        if (7'(j_q) >= 7'(hcnt_q)) begin
          state_d = S_PICK;
        end else if (cmp.owner_eq) begin
          h_rm    = 1'b1;
          hcnt_d  = hcnt_q - 1'b1;
          state_d = S_PICK;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_CANCEL: begin
        if (7'(j_q) >= 7'(qcnt_q)) begin
          state_d = S_FIN;
        end else if (cmp.owner_eq) begin
          emit_req = 1'b1;
          emit_val = '{status: lsm_pkg::StCanceled, notify_id: req_q.requester_id,
                       notify_lock: req_q.lock_id, notify_mode: ent.md, last: 1'b0};
          q_rm    = 1'b1;
          qcnt_d  = qcnt_q - 1'b1;
          state_d = S_PICK;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_PICK: begin
        j_d = '0;
        if (pi_q >= qcnt_q || n_full) begin
          state_d = S_FIN;
        end else if (hcnt_q >= HCW'(HELD_DEPTH)) begin
          pi_d = pi_q + 1'b1;
        end else begin
          state_d = S_GH;
        end
      end
      S_GH: begin
        if (7'(j_q) >= 7'(hcnt_q)) begin
          j_d     = '0;
          state_d = S_GQ;
        end else if (cmp.clash) begin
          if (av_q) begin
            emit_req = 1'b1;
            emit_val.status = lsm_pkg::StNotAvail;
            state_d = S_FIN;
          end else begin
            pi_d    = pi_q + 1'b1;
            state_d = S_PICK;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_GQ: begin
        if (7'(j_q) >= 7'(lim)) begin
          if (av_q) begin
            av_d = 1'b0;
            if (qcnt_q >= QCW'(QUEUE_DEPTH)) begin
              emit_req = 1'b1;
              emit_val.status = lsm_pkg::StFull;
              state_d = S_FIN;
            end else begin
              q_back  = 1'b1;
              qcnt_d  = qcnt_q + 1'b1;
              state_d = S_PICK;
            end
          end else begin
            // grant: move the waiter into the held table
            emit_req = 1'b1;
            emit_val = '{status: lsm_pkg::StGranted, notify_id: q_pick.who,
                         notify_lock: q_pick.lk, notify_mode: q_pick.md, last: 1'b0};
            h_push   = 1'b1;
            hcnt_d   = hcnt_q + 1'b1;
            q_rm     = 1'b1;
            q_rm_idx = pi_q[QW-1:0];
            qcnt_d   = qcnt_q - 1'b1;
            state_d  = S_PICK;
          end
        end else if (cmp.clash) begin
          if (av_q) begin
            emit_req = 1'b1;
            emit_val.status = lsm_pkg::StNotAvail;
            state_d = S_FIN;
          end else begin
            pi_d    = pi_q + 1'b1;
            state_d = S_PICK;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_FIN: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          fin_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    emit_live = emit_req && !n_full;
    stall     = emit_live && pend_valid_q && !out_free;
    if (emit_live && !stall) n_d = n_q + 1'b1;
    if (stall) begin
      state_d = state_q;
      av_d    = av_q;
      qcnt_d  = qcnt_q;
      hcnt_d  = hcnt_q;
      pi_d    = pi_q;
      j_d     = j_q;
      q_rm    = 1'b0;
      q_back  = 1'b0;
      q_front = 1'b0;
      h_rm    = 1'b0;
      h_push  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      av_q         <= 1'b0;
      qcnt_q       <= '0;
      hcnt_q       <= '0;
      pi_q         <= '0;
      j_q          <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      av_q    <= av_d;
      qcnt_q  <= qcnt_d;
      hcnt_q  <= hcnt_d;
      pi_q    <= pi_d;
      j_q     <= j_d;
      n_q     <= n_d;
      if (fin_load) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (emit_live && !stall) begin
        pend_valid_q <= 1'b1;
        if (pend_valid_q) out_valid_q <= 1'b1;
        else if (out_ready_i) out_valid_q <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
    if (fin_load) begin
      out_q <= fin_rsp;
    end else if (emit_live && !stall) begin
      pend_q <= emit_val;
      if (pend_valid_q) out_q <= pend_q;
    end
  end

  // queue and held table, shifted in place to keep order
  always_ff @(posedge clk_i) begin
    if (q_front) begin
      queue_q[0] <= cmd_slot;
      for (int k = 1; k < QUEUE_DEPTH; k++) queue_q[k] <= queue_q[k-1];
    end else if (q_back) begin
      queue_q[qcnt_q[QW-1:0]] <= cmd_slot;
    end else if (q_rm) begin
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
        if (QW'(k) >= q_rm_idx) queue_q[k] <= queue_q[k+1];
      end
    end
    if (h_rm) begin
      for (int k = 0; k < HELD_DEPTH - 1; k++) begin
        if (HW'(k) >= h_rm_idx) held_q[k] <= held_q[k+1];
      end
    end else if (h_push) begin
      held_q[hcnt_q[HW-1:0]] <= h_push_val;
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// shared/exclusive lock manager tb: directed and random commands, scoreboard against a behavioral lock model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lsm_pkg::*;

  localparam int QDepth = 16;
  localparam int HDepth = 16;
  localparam int WatchdogLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  named_shared_exclusive_lock_manager_unit #(.QUEUE_DEPTH(QDepth), .HELD_DEPTH(HDepth)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // lock model state
  slot_t waiters[$];
  slot_t holders[$];
  rsp_t  notify_q[$];
  int    batch_cnt;

  req_t  pending_cmds[$];
  int    errors = 0;
  int    accepted_cmds = 0;
  bit    stim_done = 0;
  bit    hold_off = 0;
  int    hold_cycles = 0;
  int    idle_cycles = 0;
  logic  in_ready_q = 1'b0;

  function automatic bit clashes(slot_t a, logic [7:0] lk, logic md);
    return a.lk == lk && (md == ModeExcl || a.md == ModeExcl);
  endfunction

  function automatic bit can_grant(logic [7:0] lk, logic md, int upto);
    foreach (holders[i]) if (clashes(holders[i], lk, md)) return 0;
    for (int i = 0; i < upto && i < waiters.size(); i++)
      if (clashes(waiters[i], lk, md)) return 0;
    return 1;
  endfunction

  function automatic void add_notify(logic [2:0] st, logic [7:0] who, logic [7:0] lk, logic md);
    rsp_t r;
    if (batch_cnt >= MaxResults) return;
    r.status = st; r.notify_id = who; r.notify_lock = lk; r.notify_mode = md; r.last = 1'b0;
    notify_q.insert(notify_q.size(), r);
    batch_cnt++;
  endfunction

  function automatic void regrant_pass();
    int i;
    slot_t s;
    i = 0;
    while (i < waiters.size() && batch_cnt < MaxResults) begin
      s = waiters[i];
      if (holders.size() < HDepth && can_grant(s.lk, s.md, i)) begin
        holders.insert(holders.size(), s);
        waiters.delete(i);
        add_notify(StGranted, s.who, s.lk, s.md);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic void predict_command(req_t c);
    slot_t s;
    int i;
    batch_cnt = 0;
    s.who = c.requester_id; s.lk = c.lock_id; s.md = c.mode;
    if (c.cmd == CmdRequest) begin
      if (c.steal) begin
        if (waiters.size() >= QDepth) begin
          add_notify(StFull, s.who, s.lk, s.md);
        end else begin
          i = 0;
          while (i < holders.size()) begin
            if (holders[i].lk == s.lk) begin
              add_notify(StEjected, holders[i].who, s.lk, holders[i].md);
              holders.delete(i);
            end else begin
              i++;
            end
          end
          waiters.insert(0, s);
          regrant_pass();
        end
      end else if (c.no_wait && !can_grant(s.lk, s.md, waiters.size())) begin
        add_notify(StNotAvail, s.who, s.lk, s.md);
      end else if (waiters.size() >= QDepth) begin
        add_notify(StFull, s.who, s.lk, s.md);
      end else begin
        waiters.insert(waiters.size(), s);
        regrant_pass();
      end
    end else if (c.cmd == CmdRelease) begin
      foreach (holders[k]) begin
        if (holders[k].who == s.who && holders[k].lk == s.lk) begin
          holders.delete(k);
          break;
        end
      end
      regrant_pass();
    end else if (c.cmd == CmdCancel) begin
      foreach (waiters[k]) begin
        if (waiters[k].who == s.who && waiters[k].lk == s.lk) begin
          add_notify(StCanceled, s.who, s.lk, waiters[k].md);
          waiters.delete(k);
          regrant_pass();
          break;
        end
      end
    end
    if (batch_cnt > 0) notify_q[notify_q.size() - 1].last = 1'b1;
  endfunction

  // small id and lock pools so commands collide often
  function automatic req_t random_command();
    req_t c;
    int r;
    r = $urandom_range(0, 99);
    c.cmd = (r < 55) ? CmdRequest : (r < 82) ? CmdRelease : (r < 96) ? CmdCancel : CmdNop;
    c.requester_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    c.lock_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(250, 253));
    c.mode = 1'($urandom_range(0, 1));
    c.no_wait = ($urandom_range(0, 4) == 0);
    c.steal = ($urandom_range(0, 11) == 0);
    return c;
  endfunction

  function automatic req_t mk(logic [1:0] cmd, logic [7:0] who, logic [7:0] lk,
                              logic md, logic nw, logic stl);
    req_t c;
    c.cmd = cmd; c.requester_id = who; c.lock_id = lk;
    c.mode = md; c.no_wait = nw; c.steal = stl;
    return c;
  endfunction

  function automatic void add_cmd(req_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // stimulus
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: shared pair, exclusive blocking, no-wait request, steal, release, cancel
    add_cmd(mk(CmdRequest, 8'd0, 8'd0, ModeShared, 1'b0, 1'b0));
    add_cmd(mk(CmdRequest, 8'd255, 8'd0, ModeShared, 1'b0, 1'b0));
    add_cmd(mk(CmdRequest, 8'd1, 8'd0, ModeExcl, 1'b0, 1'b0));
    add_cmd(mk(CmdRequest, 8'd2, 8'd0, ModeShared, 1'b0, 1'b0));
    add_cmd(mk(CmdRequest, 8'd3, 8'd0, ModeExcl, 1'b1, 1'b0));
    add_cmd(mk(CmdRequest, 8'd4, 8'd255, ModeExcl, 1'b1, 1'b0));
    add_cmd(mk(CmdCancel, 8'd2, 8'd0, ModeExcl, 1'b0, 1'b0));
    add_cmd(mk(CmdCancel, 8'd9, 8'd9, ModeExcl, 1'b0, 1'b0));
    add_cmd(mk(CmdRelease, 8'd0, 8'd0, ModeShared, 1'b0, 1'b0));
    add_cmd(mk(CmdRelease, 8'd255, 8'd0, ModeExcl, 1'b0, 1'b0));
    add_cmd(mk(CmdRelease, 8'd77, 8'd77, ModeExcl, 1'b0, 1'b0));
    add_cmd(mk(CmdRequest, 8'd5, 8'd255, ModeShared, 1'b1, 1'b1));
    add_cmd(mk(CmdNop, 8'd255, 8'd255, ModeShared, 1'b1, 1'b1));
    // fill the queue behind a shared holder, then overflow it
    for (int k = 0; k < 17; k++)
      add_cmd(mk(CmdRequest, 8'(10 + k), 8'd255, ModeExcl, 1'b0, 1'b0));
    add_cmd(mk(CmdRequest, 8'd40, 8'd255, ModeExcl, 1'b0, 1'b1));
    add_cmd(mk(CmdRelease, 8'd4, 8'd255, ModeExcl, 1'b0, 1'b0));
    // release commands for requesters 10 to 25 on lock 255 in turn
    for (int k = 0; k < 16; k++)
      add_cmd(mk(CmdRelease, 8'(10 + k), 8'd255, ModeExcl, 1'b0, 1'b0));
    // many shared requests on lock 7, then an exclusive steal on the same lock
    for (int k = 0; k < 18; k++)
      add_cmd(mk(CmdRequest, 8'(100 + k), 8'd7, ModeShared, 1'b0, 1'b0));
    add_cmd(mk(CmdRequest, 8'd200, 8'd7, ModeExcl, 1'b0, 1'b1));
    wait (pending_cmds.size() == 0 && notify_q.size() == 0);
    for (int k = 0; k < 350; k++) begin
      add_cmd(random_command());
      if (k == 120) begin
        wait (pending_cmds.size() == 0);
        hold_off = 1'b1;
        for (int j = 0; j < 30; j++) add_cmd(random_command());
        wait (pending_cmds.size() == 0);
        wait (hold_off == 1'b0);
      end
      if (k == 240) begin
        // sender pauses until every result has come
        wait (pending_cmds.size() == 0 && notify_q.size() == 0);
      end
    end
    wait (pending_cmds.size() == 0);
    stim_done = 1'b1;
  end

  // driver
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_q) begin
        // transaction taken at the last rising edge
        if (send_gap > 0 || pending_cmds.size() == 0) in_valid_i <= 1'b0;
        else in_data_i <= pending_cmds[0];
      end else if (!in_valid_i) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (pending_cmds.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_cmds[0];
        end
      end
    end
  end

  // acceptance at rising edge; prediction made here
  always @(posedge clk_i) begin
    in_ready_q <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_command(in_data_i);
      void'(pending_cmds.pop_front());
      accepted_cmds++;
      send_gap = gap_len();
    end
  end

  // receiver readiness
  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (hold_off) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 400) begin
        hold_off <= 1'b0;
        hold_cycles <= 0;
      end
    end else if (recv_gap > 0) begin
      out_ready_i <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap <= gap_len();
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (notify_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction %p", out_data_o);
      end else begin
        exp_rsp = notify_q.pop_front();
        if (out_data_o !== exp_rsp) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", exp_rsp, out_data_o);
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    wait (stim_done && notify_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && notify_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lsm_pkg.sv
rtl/core/lsm_compare.sv
rtl/core/named_shared_exclusive_lock_manager_unit.sv
bench/tb_top.sv
